// ----- rtl/multi_source_id_remapper_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the identifier remapper
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_SOURCE_ID_REMAPPER_ASSERT_SVH
`define MULTI_SOURCE_ID_REMAPPER_ASSERT_SVH

// Same-cycle implication.
`define MSIR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/msir_pkg.sv -----
// ----------------------------------------------------------------------------
// msir_pkg
// Shared types and constants of the identifier remapper.
// ----------------------------------------------------------------------------
package msir_pkg;

  localparam int unsigned RemapEntries = 256;
  localparam int unsigned UsedEntries  = 256;
  localparam int unsigned SourceCount  = 8;

  localparam int unsigned SrcW = 3;
  localparam int unsigned IdW  = 32;

  localparam logic [IdW-1:0] IdMax = '1;

  typedef enum logic [2:0] {
    StExisting  = 3'd0,
    StKept      = 3'd1,
    StFresh     = 3'd2,
    StFull      = 3'd3,
    StExhausted = 3'd4
  } status_e;

  // Search token moving down the cell row.
  typedef struct packed {
    logic            vld;
    logic [SrcW-1:0] src;
    logic [IdW-1:0]  id;
    logic            hit;
    logic [IdW-1:0]  asg;
    logic            taken;
  } tok_t;

  // Entry write, broadcast to all cells.
  typedef struct packed {
    logic            en;
    logic [SrcW-1:0] src;
    logic [IdW-1:0]  orig;
    logic [IdW-1:0]  asg;
  } wr_t;

endpackage

// ----- rtl/msir_cell.sv -----
// ----------------------------------------------------------------------------
// msir_cell
// One remap entry; compares the passing token and hands it on.
// ----------------------------------------------------------------------------
module msir_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned IdxW  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msir_pkg::tok_t       tok_i,
  output msir_pkg::tok_t       tok_o,
  input  msir_pkg::wr_t        wr_i,
  input  logic [IdxW-1:0]      wr_idx_i
);

  logic                          vld_q;
  logic [msir_pkg::SrcW-1:0]     src_q;
  logic [msir_pkg::IdW-1:0]      orig_q;
  logic [msir_pkg::IdW-1:0]      asg_q;
  msir_pkg::tok_t                tok_d, tok_q;
  logic                          wr_sel;

  assign wr_sel = wr_i.en && (wr_idx_i == IdxW'(Index));

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && vld_q) begin
      // first matching pair wins
      if (!tok_i.hit && (src_q == tok_i.src) && (orig_q == tok_i.id)) begin
        tok_d.hit = 1'b1;
        tok_d.asg = asg_q;
      end
      if (asg_q == tok_i.id) begin
        tok_d.taken = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_sel) begin
        vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      src_q  <= wr_i.src;
      orig_q <= wr_i.orig;
      asg_q  <= wr_i.asg;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/multi_source_id_remapper.sv -----
// ----------------------------------------------------------------------------
// multi_source_id_remapper
// Merges per-source identifiers into one id space through a row of cells.
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata               tuser
//   s_axis   in   track_id [31:0]     source [2:0]
//   m_axis   out  merged_id [31:0]    status [2:0]
//
// Path: an accepted item passes the injection register, then the row of Cells
//   cells, Cells = min(REMAP_ENTRIES, USED_ENTRIES), one cell per cycle, then
//   the done register, and its result then enters the output register.
// One item is in flight at a time; the next is accepted in the cycle after
//   its predecessor's result moves into the output register.
// Reset clears every entry's valid bit, the fill count and highest id at
//   once; no clearing pass.
// A stalled output holds the finished search until the register frees.
// ----------------------------------------------------------------------------
`include "multi_source_id_remapper_assert.svh"

module multi_source_id_remapper #(
  parameter int unsigned REMAP_ENTRIES = msir_pkg::RemapEntries,
  parameter int unsigned USED_ENTRIES  = msir_pkg::UsedEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [msir_pkg::IdW-1:0]      s_axis_tdata,   // [31:0] track_id
  input  logic [msir_pkg::SrcW-1:0]     s_axis_tuser,   // [2:0] source
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [msir_pkg::IdW-1:0]      m_axis_tdata,   // [31:0] merged_id
  output logic [2:0]                    m_axis_tuser    // [2:0] status
);

  // Remap table and used set fill together, so the smaller one bounds both.
  localparam int unsigned Cells = (REMAP_ENTRIES < USED_ENTRIES) ? REMAP_ENTRIES
                                                                 : USED_ENTRIES;
  localparam int unsigned IdxW  = $clog2(Cells);
  localparam int unsigned FillW = $clog2(Cells + 1);
  localparam int unsigned CntW  = $clog2(msir_pkg::SourceCount + 1) + 1;

  localparam int unsigned IdW  = msir_pkg::IdW;
  localparam int unsigned SrcW = msir_pkg::SrcW;

  // Control state
  logic                busy_q;
  logic                done_q;
  logic                m_valid_q;
  logic [FillW-1:0]    fill_q;
  logic [IdW-1:0]      highest_q;

  // Captured search result and output payload
  logic                done_hit_q, done_taken_q;
  logic [IdW-1:0]      done_asg_q, done_id_q;
  logic [SrcW-1:0]     done_src_q;
  logic [IdW-1:0]      m_data_q;
  msir_pkg::status_e   m_user_q;

  msir_pkg::tok_t      inj_q, inj_d;
  msir_pkg::tok_t      tok [Cells+1];
  msir_pkg::wr_t       wr;

  logic                accept, emit, store, full;
  logic [SrcW-1:0]     src_mod;
  logic [CntW-1:0]     src_work;
  msir_pkg::status_e   st;
  logic [IdW-1:0]      mapped;
  logic [IdW-1:0]      highest_d;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign emit          = done_q && (!m_valid_q || m_axis_tready);

  // Fold the source code into the configured source count.
  always_comb begin
    src_work = CntW'(s_axis_tuser);
    for (int k = 0; k < 8; k++) begin
      if (src_work >= CntW'(msir_pkg::SourceCount)) begin
        src_work = src_work - CntW'(msir_pkg::SourceCount);
      end
    end
    src_mod = src_work[SrcW-1:0];
  end

  always_comb begin
    inj_d       = '0;
    inj_d.vld   = accept;
    inj_d.src   = src_mod;
    inj_d.id    = s_axis_tdata;
  end

  assign tok[0] = inj_q;

  // Row of entry cells; the token advances one cell per cycle.
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    msir_cell #(
      .Index (g),
      .IdxW  (IdxW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .wr_i     (wr),
      .wr_idx_i (fill_q[IdxW-1:0])
    );
  end

  // Decide the mapping once the token leaves the row.
  always_comb begin
    full      = (fill_q == FillW'(Cells));
    store     = 1'b0;
    mapped    = done_id_q;
    highest_d = highest_q;
    if (done_hit_q) begin
      st     = msir_pkg::StExisting;
      mapped = done_asg_q;
    end else if (full) begin
      st = msir_pkg::StFull;
    end else if (done_taken_q && (highest_q == msir_pkg::IdMax)) begin
      st = msir_pkg::StExhausted;
    end else if (!done_taken_q) begin
      st    = msir_pkg::StKept;
      store = 1'b1;
      if (done_id_q > highest_q) begin
        highest_d = done_id_q;
      end
    end else begin
      st        = msir_pkg::StFresh;
      store     = 1'b1;
      highest_d = highest_q + 1'b1;
      mapped    = highest_d;
    end
  end

  always_comb begin
    wr.en   = emit && store;
    wr.src  = done_src_q;
    wr.orig = done_id_q;
    wr.asg  = mapped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
      fill_q    <= '0;
      highest_q <= '0;
      inj_q     <= '0;
    end else begin
      inj_q <= inj_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (emit) begin
        busy_q <= 1'b0;
      end
      // hold the finished search until the output register frees
      if (tok[Cells].vld) begin
        done_q <= 1'b1;
      end else if (emit) begin
        done_q <= 1'b0;
      end
      if (emit) begin
        m_valid_q <= 1'b1;
        highest_q <= highest_d;
        if (store) begin
          fill_q <= fill_q + 1'b1;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[Cells].vld) begin
      done_hit_q   <= tok[Cells].hit;
      done_taken_q <= tok[Cells].taken;
      done_asg_q   <= tok[Cells].asg;
      done_id_q    <= tok[Cells].id;
      done_src_q   <= tok[Cells].src;
    end
    if (emit) begin
      m_data_q <= mapped;
      m_user_q <= st;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `MSIR_ASSERT(a_fill_bound, 1'b1, fill_q <= FillW'(Cells), "fill count past capacity")
  `MSIR_ASSERT(a_tok_busy, tok[Cells].vld, busy_q && !done_q, "token without a pending item")
  `MSIR_ASSERT_NEXT(a_fill_step, emit && store, fill_q == $past(fill_q) + 1'b1, "fill not advanced")
  `MSIR_ASSERT_NEXT(a_fresh_top, emit && (st == msir_pkg::StFresh), highest_q == m_data_q, "fresh id not highest")

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for multi_source_id_remapper
// Feeds (source, track id) items through the stream input, predicts every
// remap decision with a local copy of the pair table and the issued-id set,
// and checks mapped id and status of each result in order. The table is
// never cleared, so the run walks the block through its lifetime: early
// mappings, a long random middle, the top of the id space, then a full table.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned IdW          = msir_pkg::IdW;
  localparam int unsigned SrcW         = msir_pkg::SrcW;
  localparam int unsigned RemapEntries = msir_pkg::RemapEntries;
  localparam int unsigned UsedEntries  = msir_pkg::UsedEntries;
  localparam int unsigned SourceCount  = msir_pkg::SourceCount;
  localparam logic [IdW-1:0] IdMax     = msir_pkg::IdMax;

  localparam int unsigned RandomItems    = 950;
  localparam int unsigned RandomFillCap  = 230;  // keep room for the late rows
  localparam int unsigned TailItems      = 80;
  localparam int unsigned LongHold       = 700;  // receiver hold-off, cycles
  localparam int unsigned WatchdogLimit  = 4000; // cycles without any handshake
  localparam int unsigned DrainCycles    = 300;  // > one search through all cells
  localparam int unsigned MaxPrinted     = 50;
  localparam int unsigned ScriptLen      = 22;

  typedef struct {
    logic [IdW-1:0]    id;
    msir_pkg::status_e st;
  } mapping_t;

  typedef struct {
    logic [SrcW-1:0]   src;
    logic [IdW-1:0]    id;
    bit                known;   // expectation typed in below
    logic [IdW-1:0]    exp_id;
    msir_pkg::status_e exp_st;
    bit                late;    // needs the top of the id space, runs last
  } script_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IdW-1:0]  s_axis_tdata = '0;
  logic [SrcW-1:0] s_axis_tuser = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [IdW-1:0]  m_axis_tdata;
  logic [2:0]      m_axis_tuser;

  multi_source_id_remapper dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Directed rows. Early rows chain from reset, so their results are plain.
  script_row_t script [ScriptLen] = '{
    '{3'd0, 32'h0000_0005, 1'b1, 32'h0000_0005, msir_pkg::StKept,      1'b0},
    '{3'd0, 32'h0000_0005, 1'b1, 32'h0000_0005, msir_pkg::StExisting,  1'b0},
    '{3'd1, 32'h0000_0005, 1'b1, 32'h0000_0006, msir_pkg::StFresh,     1'b0},
    '{3'd1, 32'h0000_0005, 1'b1, 32'h0000_0006, msir_pkg::StExisting,  1'b0},
    '{3'd7, 32'h0000_0000, 1'b1, 32'h0000_0000, msir_pkg::StKept,      1'b0},
    '{3'd7, 32'h0000_0006, 1'b1, 32'h0000_0007, msir_pkg::StFresh,     1'b0},
    '{3'd2, 32'h0000_0000, 1'b1, 32'h0000_0008, msir_pkg::StFresh,     1'b0},
    '{3'd3, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, msir_pkg::StKept,      1'b0},
    '{3'd4, 32'h0000_0007, 1'b1, 32'h8000_0000, msir_pkg::StFresh,     1'b0},
    '{3'd0, 32'h0000_0000, 1'b1, 32'h8000_0001, msir_pkg::StFresh,     1'b0},
    '{3'd7, 32'h0000_0000, 1'b1, 32'h0000_0000, msir_pkg::StExisting,  1'b0},
    '{3'd5, 32'h8000_0000, 1'b1, 32'h8000_0002, msir_pkg::StFresh,     1'b0},
    '{3'd6, 32'h0000_002A, 1'b1, 32'h0000_002A, msir_pkg::StKept,      1'b0},
    '{3'd3, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, msir_pkg::StExisting,  1'b0},
    '{3'd2, 32'h5555_5555, 1'b0, 32'h0000_0000, msir_pkg::StExisting,  1'b0},
    '{3'd4, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000, msir_pkg::StExisting,  1'b0},
    // Top of the id space: once the highest id is all ones it stays there.
    '{3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, msir_pkg::StKept,      1'b1},
    '{3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, msir_pkg::StExisting,  1'b1},
    '{3'd6, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, msir_pkg::StExhausted, 1'b1},
    '{3'd0, 32'hC000_0000, 1'b1, 32'hC000_0000, msir_pkg::StKept,      1'b1},
    '{3'd5, 32'hC000_0000, 1'b1, 32'hC000_0000, msir_pkg::StExhausted, 1'b1},
    '{3'd6, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE, msir_pkg::StKept,      1'b1}
  };

  // Local copy of the remap state; entries below the counts are valid.
  logic [SrcW-1:0] pair_src    [RemapEntries];
  logic [IdW-1:0]  pair_orig   [RemapEntries];
  logic [IdW-1:0]  pair_mapped [RemapEntries];
  logic [IdW-1:0]  issued_ids  [UsedEntries];
  int unsigned     pair_count = 0;
  int unsigned     issued_count = 0;
  logic [IdW-1:0]  top_id = '0;

  mapping_t        pending_maps [$];
  int unsigned     mismatches = 0;
  int unsigned     results_seen = 0;
  int unsigned     items_sent = 0;
  int unsigned     status_seen [5] = '{default: 0};
  int unsigned     burst_left = 0;

  // Decide one item and update the local state as the block should.
  function automatic mapping_t map_pair(input logic [SrcW-1:0] src_raw,
                                        input logic [IdW-1:0] id);
    mapping_t        res;
    logic [SrcW-1:0] src;
    bit              taken;
    src = SrcW'(src_raw % SourceCount);
    res.id = id;
    res.st = msir_pkg::StKept;
    for (int unsigned i = 0; i < pair_count; i++) begin
      if (pair_src[i] == src && pair_orig[i] == id) begin
        res.id = pair_mapped[i];
        res.st = msir_pkg::StExisting;
        return res;
      end
    end
    if (pair_count >= RemapEntries || issued_count >= UsedEntries) begin
      res.st = msir_pkg::StFull;
      return res;
    end
    taken = 1'b0;
    for (int unsigned i = 0; i < issued_count; i++) begin
      if (issued_ids[i] == id) taken = 1'b1;
    end
    if (taken && top_id == IdMax) begin
      res.st = msir_pkg::StExhausted;
      return res;
    end
    if (!taken) begin
      if (id > top_id) top_id = id;
    end else begin
      top_id = top_id + 1'b1;
      res.id = top_id;
      res.st = msir_pkg::StFresh;
    end
    issued_ids[issued_count] = res.id;
    issued_count++;
    pair_src[pair_count]    = src;
    pair_orig[pair_count]   = id;
    pair_mapped[pair_count] = res.id;
    pair_count++;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [IdW-1:0] exp_v,
                                 input logic [IdW-1:0] got_v);
    if (mismatches < MaxPrinted)
      $display("MISMATCH %s: expected %08h, got %08h (result %0d)",
               what, exp_v, got_v, results_seen);
    mismatches++;
  endtask

  // Offer one item in a burst; hold it until accepted, then queue its mapping.
  // Called and returning at a falling edge.
  task automatic offer_item(input logic [SrcW-1:0] src, input logic [IdW-1:0] id,
                            input bit known, input mapping_t typed);
    mapping_t predicted;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 400) : $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id;
    s_axis_tuser  <= src;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = map_pair(src, id);
    pending_maps.insert(pending_maps.size(), known ? typed : predicted);
    items_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic run_script(input bit late);
    for (int unsigned r = 0; r < ScriptLen; r++) begin
      if (script[r].late == late)
        offer_item(script[r].src, script[r].id, script[r].known,
                   '{script[r].exp_id, script[r].exp_st});
    end
  endtask

  // Look up a pair already in the table.
  task automatic offer_known_pair();
    int unsigned k;
    k = $urandom_range(0, pair_count - 1);
    offer_item(pair_src[k], pair_orig[k], 1'b0, '{'0, msir_pkg::StExisting});
  endtask

  // Stimulus
  initial begin
    mapping_t    none;
    int unsigned roll;
    logic [IdW-1:0] id;
    none = '{'0, msir_pkg::StExisting};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_script(1'b0);

    // Mostly lookups of known pairs, some pairs that reuse an issued id (a new
    // pair then gets a fresh id), some new pairs with ids of their own.
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) begin
        // Let the pipeline run dry once before going on.
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (pending_maps.size() != 0);
        burst_left = 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 65 || pair_count >= RandomFillCap) begin
        offer_known_pair();
      end else if (roll < 82) begin
        offer_item(SrcW'($urandom_range(0, SourceCount - 1)),
                   issued_ids[$urandom_range(0, issued_count - 1)], 1'b0, none);
      end else begin
        id = ($urandom_range(0, 3) == 0) ? IdW'($urandom_range(0, 255))
                                         : ($urandom & 32'h7FFF_FFFF);
        offer_item(SrcW'($urandom_range(0, SourceCount - 1)), id, 1'b0, none);
      end
    end

    run_script(1'b1);

    // Fill the table with new pairs; colliding ids now come back exhausted.
    while (pair_count < RemapEntries)
      offer_item(SrcW'($urandom_range(0, SourceCount - 1)),
                 $urandom | 32'h8000_0000, 1'b0, none);

    // Full table: new pairs are refused, known pairs still resolve.
    for (int unsigned n = 0; n < TailItems; n++) begin
      if ($urandom_range(0, 1) == 0)
        offer_known_pair();
      else
        offer_item(SrcW'($urandom_range(0, SourceCount - 1)), $urandom, 1'b0, none);
    end

    s_axis_tvalid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Summary: %0d items, %0d results, table holds %0d pairs, top id %08h",
             items_sent, results_seen, pair_count, top_id);
    $display("Summary: existing %0d, kept %0d, fresh %0d, full %0d, exhausted %0d",
             status_seen[msir_pkg::StExisting], status_seen[msir_pkg::StKept],
             status_seen[msir_pkg::StFresh], status_seen[msir_pkg::StFull],
             status_seen[msir_pkg::StExhausted]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: drive tready in one of three random stall modes; hold off once for a long
  // stretch so the block backs up into its input.
  initial begin
    int unsigned rx_mode;
    int unsigned rx_left;
    bit          long_hold_done;
    rx_mode = 0;
    rx_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= 40) begin
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = 64;
        end
        rx_left--;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    mapping_t exp_map;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_maps.size() == 0) begin
        report_mismatch("result with nothing pending", '0, m_axis_tdata);
      end else begin
        exp_map = pending_maps.pop_front();
        if (m_axis_tdata !== exp_map.id)
          report_mismatch("merged_id", exp_map.id, m_axis_tdata);
        if (m_axis_tuser !== exp_map.st)
          report_mismatch("status", IdW'(exp_map.st), IdW'(m_axis_tuser));
      end
      if (m_axis_tuser <= msir_pkg::StExhausted) status_seen[m_axis_tuser]++;
      results_seen++;
    end
  end

  // Watchdog: end the run when no handshake happens for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no handshake for %0d cycles, %0d results pending",
             WatchdogLimit, pending_maps.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- multi_source_id_remapper.f -----
+incdir+rtl
rtl/msir_pkg.sv
rtl/msir_cell.sv
rtl/multi_source_id_remapper.sv
verif/tb.sv
